@@ hdl/paq_pkg.sv @@
// ----------------------------------------------------------------------------
// Ready queue package
// Shared types, codes and a helper function for the priority/affinity ready
// queue.
// ----------------------------------------------------------------------------
package paq_pkg;

  localparam int THREAD_W    = 8;
  localparam int PRIO_W      = 4;
  localparam int CORE_W      = 3;
  localparam int STATUS_W    = 3;
  localparam int OCC_W       = 6;
  localparam int PRIO_LEVELS = 1 << PRIO_W;

  typedef enum logic [STATUS_W-1:0] {
    STAT_ENQUEUED    = 3'd0,
    STAT_IGNORED     = 3'd1,
    STAT_FULL_DROP   = 3'd2,
    STAT_PICKED      = 3'd3,
    STAT_IDLE_CHOSEN = 3'd4
  } status_t;

  typedef enum logic {
    ACT_ENQUEUE = 1'b0,
    ACT_PICK    = 1'b1
  } action_t;

  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } fsm_t;

  typedef struct packed {
    logic [THREAD_W-1:0] thread;
    logic [PRIO_W-1:0]   prio;
    logic                any_core;
    logic [CORE_W-1:0]   core;
  } entry_t;

  typedef struct packed {
    logic              rank_en;
    logic [CORE_W-1:0] rank_core;
    logic [PRIO_W-1:0] best_prio;
    logic              commit_pick;
    entry_t            enq_ent;
  } cell_ctrl_t;

  // Returns the highest priority level whose bit is set, zero if none.
  function automatic logic [PRIO_W-1:0] top_prio(input logic [PRIO_LEVELS-1:0] mask);
    logic [PRIO_W-1:0] res;
    res = '0;
    for (int p = 0; p < PRIO_LEVELS; p++) begin
      if (mask[p]) begin
        res = PRIO_W'(p);
      end
    end
    return res;
  endfunction

endpackage

@@ hdl/paq_if.sv @@
// ----------------------------------------------------------------------------
// Ready queue channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface paq_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] thread_id;
  logic [3:0] priority_req;
  logic       any_core;
  logic [2:0] bound_core;
  logic [2:0] asking_core;

  modport source (
    output valid, action, thread_id, priority_req, any_core, bound_core, asking_core,
    input  ready
  );
  modport sink (
    input  valid, action, thread_id, priority_req, any_core, bound_core, asking_core,
    output ready
  );
endinterface

interface paq_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] picked_thread;
  logic [3:0] picked_priority;
  logic [5:0] occupancy;

  modport source (
    output valid, status, picked_thread, picked_priority, occupancy,
    input  ready
  );
  modport sink (
    input  valid, status, picked_thread, picked_priority, occupancy,
    output ready
  );
endinterface

@@ hdl/paq_cell.sv @@
// ----------------------------------------------------------------------------
// Ready queue cell
// Holds one queue slot, ranks it against the asking core and shifts in its
// upper neighbor when an earlier or this slot is removed; loads a new entry.
// ----------------------------------------------------------------------------
module paq_cell (
  input  logic                clk,
  input  paq_pkg::cell_ctrl_t ctrl,
  input  logic                valid_i,
  input  logic                load_i,
  input  logic                hit_i,
  input  paq_pkg::entry_t     next_i,
  output paq_pkg::entry_t     ent_o,
  output logic [paq_pkg::PRIO_LEVELS-1:0] prio_mask_o,
  output logic                hit_o,
  output logic                sel_o
);
  import paq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;
  logic   match_r;
  logic   match_now;
  logic   cand;

  assign match_now   = valid_i & (ent_r.any_core | (ent_r.core == ctrl.rank_core));
  assign prio_mask_o = match_now ? (PRIO_LEVELS'(1) << ent_r.prio) : '0;

  assign cand  = match_r & (ent_r.prio == ctrl.best_prio);
  assign hit_o = hit_i | cand;
  assign sel_o = cand & ~hit_i;
  assign ent_o = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (load_i) begin
      ent_nxt = ctrl.enq_ent;
    end else if (ctrl.commit_pick && hit_o) begin
      ent_nxt = next_i;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (ctrl.rank_en) begin
      match_r <= match_now;
    end
  end

endmodule

@@ hdl/priority_affinity_ready_queue_top.sv @@
// ----------------------------------------------------------------------------
// Priority/affinity ready queue
// Scheduler ready queue built as a row of cells: enqueue at the tail, pick
// the best entry for a core and close the gap by shifting the row.
// ----------------------------------------------------------------------------
// Flow: a new item is accepted only while the controller is idle; the accept
// cycle ranks all cells in parallel and the next cycle selects, shifts the
// cell row and loads the result register, waiting there while a previous
// result is not yet taken.
// Reset: clears the entry count, the controller and the result valid; the
// slot contents are not cleared and need no clearing pass.
module priority_affinity_ready_queue_top #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  paq_in_if.sink        in_ch,
  paq_out_if.source     out_ch
);
  import paq_pkg::*;

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  fsm_t                  state_r;
  fsm_t                  state_nxt;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;
  logic                  req_pick_r;
  entry_t                req_ent_r;
  logic [PRIO_W-1:0]     best_prio_r;
  logic                  out_valid_r;
  status_t               out_status_r;
  status_t               status_nxt;
  logic [THREAD_W-1:0]   out_thread_r;
  logic [PRIO_W-1:0]     out_prio_r;
  logic [OCC_W-1:0]      out_occ_r;

  logic                  in_acc;
  logic                  out_free;
  logic                  commit;
  logic                  found;
  logic                  full;
  logic                  enq_ok;
  logic [PRIO_LEVELS-1:0] rank_mask;
  logic [THREAD_W-1:0]   sel_thread;
  logic [CW+OCC_W-1:0]   occ_wide;
  cell_ctrl_t            ctrl;

  entry_t                ent     [QUEUE_DEPTH];
  logic [PRIO_LEVELS-1:0] pmask  [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0]  hit_chain;
  logic [QUEUE_DEPTH-1:0] sel_vec;

  assign in_acc   = in_ch.valid & in_ch.ready;
  assign out_free = ~out_valid_r | out_ch.ready;
  assign found    = best_prio_r != '0;
  assign full     = count_r == CW'(QUEUE_DEPTH);
  assign enq_ok   = ~req_pick_r & (req_ent_r.prio != '0) & ~full;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: begin
        if (in_acc) begin
          state_nxt = FSM_EXEC;
        end
      end
      FSM_EXEC: begin
        if (out_free) begin
          state_nxt = FSM_IDLE;
        end
      end
      default: state_nxt = FSM_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    commit      = 1'b0;
    case (state_r)
      FSM_IDLE: in_ch.ready = 1'b1;
      FSM_EXEC: commit      = out_free;
      default: begin
        in_ch.ready = 1'b0;
        commit      = 1'b0;
      end
    endcase
  end

  assign ctrl.rank_en     = in_acc & (in_ch.action == ACT_PICK);
  assign ctrl.rank_core   = in_ch.asking_core;
  assign ctrl.best_prio   = best_prio_r;
  assign ctrl.commit_pick = commit & req_pick_r & found;
  assign ctrl.enq_ent     = req_ent_r;

  assign hit_chain[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic   valid_c;
    logic   load_c;
    entry_t next_c;

    assign valid_c = CW'(i) < count_r;
    assign load_c  = commit & enq_ok & (count_r == CW'(i));
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign next_c = '0;
    end else begin : g_mid
      assign next_c = ent[i+1];
    end

    paq_cell u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .valid_i     (valid_c),
      .load_i      (load_c),
      .hit_i       (hit_chain[i]),
      .next_i      (next_c),
      .ent_o       (ent[i]),
      .prio_mask_o (pmask[i]),
      .hit_o       (hit_chain[i+1]),
      .sel_o       (sel_vec[i])
    );
  end

  always_comb begin
    rank_mask  = '0;
    sel_thread = '0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rank_mask  = rank_mask | pmask[i];
      sel_thread = sel_thread | (sel_vec[i] ? ent[i].thread : '0);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    status_nxt = STAT_IDLE_CHOSEN;
    if (req_pick_r) begin
      if (found) begin
        status_nxt = STAT_PICKED;
        count_nxt  = count_r - CW'(1);
      end
    end else if (req_ent_r.prio == '0) begin
      status_nxt = STAT_IGNORED;
    end else if (full) begin
      status_nxt = STAT_FULL_DROP;
    end else begin
      status_nxt = STAT_ENQUEUED;
      count_nxt  = count_r + CW'(1);
    end
  end

  assign occ_wide = {{OCC_W{1'b0}}, count_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r     <= count_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_pick_r  <= in_ch.action == ACT_PICK;
      req_ent_r   <= '{thread:   in_ch.thread_id,
                       prio:     in_ch.priority_req,
                       any_core: in_ch.any_core,
                       core:     in_ch.bound_core};
      best_prio_r <= (in_ch.action == ACT_PICK) ? top_prio(rank_mask) : '0;
    end
    if (commit) begin
      out_status_r <= status_nxt;
      out_thread_r <= (req_pick_r & found) ? sel_thread : '0;
      out_prio_r   <= req_pick_r ? best_prio_r : '0;
      out_occ_r    <= occ_wide[OCC_W-1:0];
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.status          = out_status_r;
  assign out_ch.picked_thread   = out_thread_r;
  assign out_ch.picked_priority = out_prio_r;
  assign out_ch.occupancy       = out_occ_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("entry count exceeds the queue depth");

  a_single_sel: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(sel_vec))
    else $error("more than one cell selected for removal");

  a_pick_removes: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && req_pick_r && found) |=> (count_r == $past(count_r) - CW'(1)))
    else $error("a successful pick did not remove one entry");

  a_found_has_sel: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_EXEC && req_pick_r && found) |-> (sel_vec != '0))
    else $error("a ranked priority has no matching cell");

endmodule
